// ===== design/lptd_pkg.sv =====
// Shared types and constants for the leaf position tag decoder.
package lptd_pkg;

   typedef enum logic [2:0] {
      TAG_HASH      = 3'd0,
      TAG_RELATIVE  = 3'd1,
      TAG_ABSOLUTE  = 3'd2,
      TAG_ABOVE_BASE = 3'd3,
      TAG_FROM_PREV = 3'd4,
      TAG_REPEAT    = 3'd5,
      TAG_SEPARATOR = 3'd6
   } tag_kind_type;

   typedef enum logic [1:0] {
      RESULT_ENTRY = 2'd0,
      RESULT_END   = 2'd1,
      RESULT_ERROR = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_BEYOND      = 2'd1,
      ERR_NO_PREVIOUS = 2'd2,
      ERR_NEGATIVE    = 2'd3
   } error_code_type;

   localparam logic [31:0] BASE_512MIB = 32'h2000_0000;

   typedef struct packed {
      tag_kind_type        tag_kind;
      logic signed [31:0]  tag_value;
      logic [63:0]         hash_value;
      logic [30:0]         bucket_offset;
   } item_type;

   typedef struct packed {
      logic            valid;
      result_kind_type result_kind;
      logic [63:0]     entry_hash;
      logic [31:0]     leaf_position;
      error_code_type  error_code;
   } result_type;

endpackage

// ===== design/lptd_in_reg.sv =====
// Input register stage: captures one tag beat per cycle while each held beat is taken.
module lptd_in_reg
   import lptd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  logic     take,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign in_ready   = !valid_ff || take;
   assign valid_in   = in_ready ? in_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== design/lptd_decode.sv =====
// Tag decode logic and decoder state (current hash, previous position).
module lptd_decode
   import lptd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   input  logic       take,
   output result_type result
);

   logic [63:0] hash_ff;
   logic [63:0] hash_in;
   logic [31:0] prev_ff;
   logic [31:0] prev_in;
   logic        have_ff;
   logic        have_in;

   logic [31:0] uval;
   logic [31:0] rel_pos;
   logic        rel_beyond;
   logic [32:0] prev_diff;
   result_type  res;

   assign uval       = item.tag_value;
   assign rel_pos    = {1'b0, item.bucket_offset} - uval;
   assign rel_beyond = !item.tag_value[31] && (item.tag_value[30:0] > item.bucket_offset);
   assign prev_diff  = {prev_ff[31], prev_ff} - {item.tag_value[31], uval};

   always_comb begin
      res               = '0;
      res.result_kind   = RESULT_ENTRY;
      res.error_code    = ERR_NONE;
      res.entry_hash    = hash_ff;
      unique case (item.tag_kind)
         TAG_HASH: begin
            res.valid = 1'b0;
         end
         TAG_RELATIVE: begin
            res.valid = 1'b1;
            if (rel_beyond) begin
               res.result_kind = RESULT_ERROR;
               res.error_code  = ERR_BEYOND;
            end else begin
               res.leaf_position = rel_pos;
            end
         end
         TAG_ABSOLUTE: begin
            res.valid         = 1'b1;
            res.leaf_position = uval;
         end
         TAG_ABOVE_BASE: begin
            res.valid         = 1'b1;
            res.leaf_position = BASE_512MIB + uval;
         end
         TAG_FROM_PREV: begin
            res.valid = 1'b1;
            if (!have_ff) begin
               res.result_kind = RESULT_ERROR;
               res.error_code  = ERR_NO_PREVIOUS;
            end else if (prev_diff[32]) begin
               res.result_kind = RESULT_ERROR;
               res.error_code  = ERR_NEGATIVE;
            end else begin
               res.leaf_position = prev_diff[31:0];
            end
         end
         TAG_REPEAT: begin
            res.valid = 1'b1;
            if (!have_ff) begin
               res.result_kind = RESULT_ERROR;
               res.error_code  = ERR_NO_PREVIOUS;
            end else begin
               res.leaf_position = prev_ff;
            end
         end
         TAG_SEPARATOR: begin
            res.valid       = 1'b1;
            res.result_kind = RESULT_END;
         end
         default: begin
            res.valid = 1'b0;
         end
      endcase
      if (res.result_kind != RESULT_ENTRY) begin
         res.entry_hash    = '0;
         res.leaf_position = '0;
      end
      res.valid = res.valid && item_valid;
   end

   assign result = res;

   always_comb begin
      hash_in = hash_ff;
      prev_in = prev_ff;
      have_in = have_ff;
      if (take) begin
         if (item.tag_kind == TAG_HASH) begin
            hash_in = item.hash_value;
         end else if (res.valid && res.result_kind == RESULT_ENTRY) begin
            prev_in = res.leaf_position;
            have_in = 1'b1;
         end else if (res.valid) begin
            hash_in = '0;
            prev_in = '0;
            have_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         prev_ff <= '0;
         have_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         prev_ff <= prev_in;
         have_ff <= have_in;
      end
   end

endmodule

// ===== design/lptd_out_reg.sv =====
// Result register stage: holds one result beat until the sink takes it.
module lptd_out_reg
   import lptd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       free,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign free       = !valid_ff || out_ready;
   assign valid_in   = free ? result.valid : valid_ff;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (free && result.valid) begin
         result_ff <= result;
      end
   end

endmodule

// ===== design/leaf_position_tag_decoder.sv =====
// Top level of the leaf position tag decoder.
// Takes one tag beat per clock and turns it into at most one result beat: a
// (hash, leaf position) entry, an end-of-bucket marker or an error. A tag
// passes through an input register, the decode logic (a 33-bit subtract from
// the previous position or a 32-bit add or subtract against the base or the
// bucket offset) and a result register that holds each beat until the sink
// takes it. The block sustains one tag per cycle while the result side keeps
// taking beats. Hash tags and unused tag kinds produce no result beat.
module leaf_position_tag_decoder
   import lptd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] tag_value, [95:32] hash_value, [126:96] bucket_offset, [127] zero
   input  logic [127:0] req_tdata,
   // [2:0] tag_kind
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] entry_hash, [95:64] leaf_position, [97:96] error_code, [103:98] zero
   output logic [103:0] rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]   rsp_tuser
);

   item_type   in_item;
   item_type   item;
   logic       item_valid;
   logic       take;
   logic       out_free;
   result_type result;
   result_type out_result;

   assign in_item.tag_kind      = tag_kind_type'(req_tuser);
   assign in_item.tag_value     = req_tdata[31:0];
   assign in_item.hash_value    = req_tdata[95:32];
   assign in_item.bucket_offset = req_tdata[126:96];

   assign take = item_valid && (out_free || !result.valid);

   lptd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   lptd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .result     (result)
   );

   lptd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .free       (out_free),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   assign rsp_tdata = {6'd0, out_result.error_code, out_result.leaf_position,
                       out_result.entry_hash};
   assign rsp_tuser = out_result.result_kind;

endmodule

// ===== design/lptd_checker.sv =====
// Port-level checks for the leaf position tag decoder, bound to the top level.
module lptd_port_checks
   import lptd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [2:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == RESULT_ENTRY || rsp_tuser == RESULT_END ||
                      rsp_tuser == RESULT_ERROR))
      else $error("bad result kind");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == RESULT_ERROR |->
         rsp_tdata[97:96] != ERR_NONE && rsp_tdata[95:0] == '0)
      else $error("malformed error beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != RESULT_ERROR |-> rsp_tdata[97:96] == ERR_NONE)
      else $error("error code on non-error beat");

   // a hash tag alone never produces a result beat
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && $past(!rsp_tvalid) && $past(req_tvalid && req_tready &&
         req_tuser == TAG_HASH, 2) && $past(!req_tvalid, 1) |=> !rsp_tvalid)
      else $error("result beat from hash tag");

endmodule

bind leaf_position_tag_decoder lptd_port_checks u_lptd_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
